@@ src/xalu_pkg.sv @@
// Shared types, codes and helper functions for the x86 integer ALU.
// No dependencies; used by every module of the block.
`default_nettype none

package xalu_pkg;

  // Operation codes carried on the mode field
  typedef enum logic [4:0] {
    MODE_ADD  = 5'd0,
    MODE_ADC  = 5'd1,
    MODE_SUB  = 5'd2,
    MODE_SBB  = 5'd3,
    MODE_AND  = 5'd4,
    MODE_OR   = 5'd5,
    MODE_XOR  = 5'd6,
    MODE_ROL  = 5'd7,
    MODE_ROR  = 5'd8,
    MODE_RCL  = 5'd9,
    MODE_RCR  = 5'd10,
    MODE_SHL  = 5'd11,
    MODE_SHR  = 5'd12,
    MODE_SAR  = 5'd13,
    MODE_MUL  = 5'd14,
    MODE_IMUL = 5'd15,
    MODE_COND = 5'd16,
    MODE_LDF  = 5'd17
  } mode_e;

  // Operand size codes; the spare code behaves as 32 bits
  typedef enum logic [1:0] {
    WIDTH_8  = 2'd0,
    WIDTH_16 = 2'd1,
    WIDTH_32 = 2'd2
  } width_e;

  // Jcc condition pairs (condition code without its invert bit)
  typedef enum logic [2:0] {
    CC_O  = 3'd0,
    CC_B  = 3'd1,
    CC_Z  = 3'd2,
    CC_BE = 3'd3,
    CC_S  = 3'd4,
    CC_P  = 3'd5,
    CC_L  = 3'd6,
    CC_LE = 3'd7
  } cc_e;

  // Status flags, packed so that bit 0 is CF and bit 5 is OF
  typedef struct packed {
    logic of;
    logic sf;
    logic zf;
    logic af;
    logic pf;
    logic cf;
  } flags_t;

  function automatic logic [31:0] width_mask(logic [1:0] ws);
    logic [31:0] m;
    case (width_e'(ws))
      WIDTH_8:  m = 32'h0000_00FF;
      WIDTH_16: m = 32'h0000_FFFF;
      default:  m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  // Sign bit of a value at the selected size
  function automatic logic top_bit(logic [31:0] v, logic [1:0] ws);
    logic t;
    case (width_e'(ws))
      WIDTH_8:  t = v[7];
      WIDTH_16: t = v[15];
      default:  t = v[31];
    endcase
    return t;
  endfunction

  // Bit just below the sign bit
  function automatic logic next_bit(logic [31:0] v, logic [1:0] ws);
    logic t;
    case (width_e'(ws))
      WIDTH_8:  t = v[6];
      WIDTH_16: t = v[14];
      default:  t = v[30];
    endcase
    return t;
  endfunction

  // PF, ZF and SF from a result already masked to the size
  function automatic flags_t set_szp(flags_t f, logic [31:0] s, logic [1:0] ws);
    flags_t r;
    r    = f;
    r.pf = ~^s[7:0];
    r.zf = (s == 32'd0);
    r.sf = top_bit(s, ws);
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/xalu_arith.sv @@
// Add, subtract (with carry or borrow) and bitwise logic with their flags.
// Depends on xalu_pkg.
`default_nettype none

module xalu_arith import xalu_pkg::*; (
  input  mode_e       mode_i,
  input  logic [1:0]  width_i,
  input  logic [31:0] a_i,      // masked to size
  input  logic [31:0] b_i,      // masked to size
  input  flags_t      flags_i,
  output logic [31:0] res_o,
  output flags_t      flags_o
);

  logic [31:0] mask;
  logic        cin;
  logic        bin;
  logic [32:0] sum;
  logic [32:0] dif;
  logic [31:0] sum_m;
  logic [31:0] dif_m;
  logic        sum_c;
  logic [31:0] logic_res;

  assign mask  = width_mask(width_i);
  assign cin   = (mode_i == MODE_ADC) & flags_i.cf;
  assign bin   = (mode_i == MODE_SBB) & flags_i.cf;
  assign sum   = {1'b0, a_i} + {1'b0, b_i} + {32'd0, cin};
  assign dif   = {1'b0, a_i} - {1'b0, b_i} - {32'd0, bin};
  assign sum_m = sum[31:0] & mask;
  assign dif_m = dif[31:0] & mask;

  // carry out of the top bit at the selected size
  always_comb begin
    case (width_e'(width_i))
      WIDTH_8:  sum_c = sum[8];
      WIDTH_16: sum_c = sum[16];
      default:  sum_c = sum[32];
    endcase
  end

  always_comb begin
    case (mode_i)
      MODE_AND: logic_res = a_i & b_i;
      MODE_OR:  logic_res = a_i | b_i;
      default:  logic_res = a_i ^ b_i;
    endcase
  end

  always_comb begin
    res_o   = 32'd0;
    flags_o = flags_i;
    case (mode_i)
      MODE_ADD, MODE_ADC: begin
        res_o      = sum_m;
        flags_o.cf = sum_c;
        flags_o.af = a_i[4] ^ b_i[4] ^ sum_m[4];
        flags_o.of = top_bit((a_i ^ sum_m) & (b_i ^ sum_m), width_i);
        flags_o    = set_szp(flags_o, sum_m, width_i);
      end
      MODE_SUB, MODE_SBB: begin
        // operands are below 2^32, so bit 32 is the borrow
        res_o      = dif_m;
        flags_o.cf = dif[32];
        flags_o.af = a_i[4] ^ b_i[4] ^ dif_m[4];
        flags_o.of = top_bit((a_i ^ b_i) & (a_i ^ dif_m), width_i);
        flags_o    = set_szp(flags_o, dif_m, width_i);
      end
      MODE_AND, MODE_OR, MODE_XOR: begin
        res_o      = logic_res;
        flags_o.cf = 1'b0;
        flags_o.of = 1'b0;
        flags_o    = set_szp(flags_o, logic_res, width_i);
      end
      default: begin
        res_o   = 32'd0;
        flags_o = flags_i;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/xalu_shift.sv @@
// Barrel rotator and shifter: ROL, ROR, RCL, RCR, SHL, SHR, SAR with flags.
// Depends on xalu_pkg.
`default_nettype none

module xalu_shift import xalu_pkg::*; (
  input  mode_e       mode_i,
  input  logic [1:0]  width_i,
  input  logic [31:0] a_i,      // masked to size
  input  logic [4:0]  cnt_i,
  input  flags_t      flags_i,
  output logic [31:0] res_o,
  output flags_t      flags_o
);

  logic [31:0] mask;
  logic [31:0] rep;
  logic [63:0] rol_dbl;
  logic [63:0] ror_dbl;
  logic [31:0] rol_res;
  logic [31:0] ror_res;
  logic [65:0] rc_dbl;
  logic [4:0]  rc_cnt;
  logic [65:0] rcl_dbl;
  logic [65:0] rcr_dbl;
  logic [31:0] rcl_res;
  logic [31:0] rcr_res;
  logic        rcl_c;
  logic        rcr_c;
  logic [63:0] shl_ext;
  logic [31:0] shl_res;
  logic        shl_c;
  logic [32:0] shr_ext;
  logic [31:0] sa;
  logic [32:0] sar_ext;
  logic        msb_a;
  logic        cnt_nz;
  logic        cnt_one;

  assign mask    = width_mask(width_i);
  assign msb_a   = top_bit(a_i, width_i);
  assign cnt_nz  = (cnt_i != 5'd0);
  assign cnt_one = (cnt_i == 5'd1);

  // Plain rotates: the operand repeated across 32 bits rotates by the
  // count modulo its own size.
  always_comb begin
    case (width_e'(width_i))
      WIDTH_8:  rep = {4{a_i[7:0]}};
      WIDTH_16: rep = {2{a_i[15:0]}};
      default:  rep = a_i;
    endcase
  end

  assign rol_dbl = {rep, rep} << cnt_i;
  assign ror_dbl = {rep, rep} >> cnt_i;
  assign rol_res = rol_dbl[63:32] & mask;
  assign ror_res = ror_dbl[31:0] & mask;

  // Rotates through carry work on the size plus one bit, count modulo that
  always_comb begin
    case (width_e'(width_i))
      WIDTH_8: begin
        rc_dbl = {48'd0, flags_i.cf, a_i[7:0], flags_i.cf, a_i[7:0]};
        if (cnt_i >= 5'd27)      rc_cnt = 5'(cnt_i - 5'd27);
        else if (cnt_i >= 5'd18) rc_cnt = 5'(cnt_i - 5'd18);
        else if (cnt_i >= 5'd9)  rc_cnt = 5'(cnt_i - 5'd9);
        else                     rc_cnt = cnt_i;
      end
      WIDTH_16: begin
        rc_dbl = {32'd0, flags_i.cf, a_i[15:0], flags_i.cf, a_i[15:0]};
        rc_cnt = (cnt_i >= 5'd17) ? 5'(cnt_i - 5'd17) : cnt_i;
      end
      default: begin
        rc_dbl = {flags_i.cf, a_i, flags_i.cf, a_i};
        rc_cnt = cnt_i;
      end
    endcase
  end

  assign rcl_dbl = rc_dbl << rc_cnt;
  assign rcr_dbl = rc_dbl >> rc_cnt;

  always_comb begin
    case (width_e'(width_i))
      WIDTH_8: begin
        rcl_c   = rcl_dbl[17];
        rcl_res = {24'd0, rcl_dbl[16:9]};
        rcr_c   = rcr_dbl[8];
        rcr_res = {24'd0, rcr_dbl[7:0]};
      end
      WIDTH_16: begin
        rcl_c   = rcl_dbl[33];
        rcl_res = {16'd0, rcl_dbl[32:17]};
        rcr_c   = rcr_dbl[16];
        rcr_res = {16'd0, rcr_dbl[15:0]};
      end
      default: begin
        rcl_c   = rcl_dbl[65];
        rcl_res = rcl_dbl[64:33];
        rcr_c   = rcr_dbl[32];
        rcr_res = rcr_dbl[31:0];
      end
    endcase
  end

  // Shifts: an extra bit beside the operand catches the last bit out
  assign shl_ext = {32'd0, a_i} << cnt_i;
  assign shl_res = shl_ext[31:0] & mask;

  always_comb begin
    case (width_e'(width_i))
      WIDTH_8:  shl_c = shl_ext[8];
      WIDTH_16: shl_c = shl_ext[16];
      default:  shl_c = shl_ext[32];
    endcase
  end

  assign shr_ext = {a_i, 1'b0} >> cnt_i;
  assign sa      = (a_i & mask) | ({32{msb_a}} & ~mask);
  assign sar_ext = $signed({sa, 1'b0}) >>> cnt_i;

  always_comb begin
    res_o   = a_i;
    flags_o = flags_i;
    case (mode_i)
      MODE_ROL: begin
        res_o = rol_res;
        if (cnt_nz) begin
          flags_o.cf = rol_res[0];
          flags_o.of = cnt_one & (top_bit(rol_res, width_i) ^ rol_res[0]);
        end
      end
      MODE_ROR: begin
        res_o = ror_res;
        if (cnt_nz) begin
          flags_o.cf = top_bit(ror_res, width_i);
          flags_o.of = cnt_one &
                       (top_bit(ror_res, width_i) ^ next_bit(ror_res, width_i));
        end
      end
      MODE_RCL: begin
        res_o = rcl_res;
        if (cnt_nz) flags_o.cf = rcl_c;
        if (cnt_one) flags_o.of = top_bit(rcl_res, width_i) ^ rcl_c;
      end
      MODE_RCR: begin
        res_o = rcr_res;
        if (cnt_nz) flags_o.cf = rcr_c;
        if (cnt_one) flags_o.of = msb_a ^ flags_i.cf;
      end
      MODE_SHL: begin
        res_o = shl_res;
        if (cnt_nz) begin
          flags_o    = set_szp(flags_i, shl_res, width_i);
          flags_o.cf = shl_c;
          flags_o.of = cnt_one & (top_bit(shl_res, width_i) ^ shl_c);
        end
      end
      MODE_SHR: begin
        res_o = shr_ext[32:1];
        if (cnt_nz) begin
          flags_o    = set_szp(flags_i, shr_ext[32:1], width_i);
          flags_o.cf = shr_ext[0];
          flags_o.of = cnt_one & msb_a;
        end
      end
      MODE_SAR: begin
        res_o = sar_ext[32:1] & mask;
        if (cnt_nz) begin
          flags_o    = set_szp(flags_i, sar_ext[32:1] & mask, width_i);
          flags_o.cf = sar_ext[0];
          flags_o.of = 1'b0;
        end
      end
      default: begin
        res_o   = a_i;
        flags_o = flags_i;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/xalu_mul.sv @@
// Combinational 33x33 signed multiplier serving MUL and IMUL at every size.
// Depends on xalu_pkg.
`default_nettype none

module xalu_mul import xalu_pkg::*; (
  input  logic        signed_i,
  input  logic [1:0]  width_i,
  input  logic [31:0] a_i,      // masked to size
  input  logic [31:0] b_i,      // masked to size
  output logic [31:0] lo_o,
  output logic [31:0] hi_o,
  output logic        ovf_o
);

  logic [31:0] mask;
  logic        sa;
  logic        sb;
  logic [32:0] xa;
  logic [32:0] xb;
  logic [65:0] prod;

  assign mask = width_mask(width_i);
  assign sa   = signed_i & top_bit(a_i, width_i);
  assign sb   = signed_i & top_bit(b_i, width_i);
  assign xa   = {sa, (a_i & mask) | ({32{sa}} & ~mask)};
  assign xb   = {sb, (b_i & mask) | ({32{sb}} & ~mask)};
  assign prod = $signed(xa) * $signed(xb);

  assign lo_o = prod[31:0] & mask;

  always_comb begin
    case (width_e'(width_i))
      WIDTH_8:  hi_o = {24'd0, prod[15:8]};
      WIDTH_16: hi_o = {16'd0, prod[31:16]};
      default:  hi_o = prod[63:32];
    endcase
  end

  // unsigned: any high bit; signed: high half is not the sign of the low
  assign ovf_o = signed_i ? (hi_o != ({32{top_bit(lo_o, width_i)}} & mask))
                          : (hi_o != 32'd0);

endmodule

`default_nettype wire

@@ src/x86_integer_alu_with_flags.sv @@
// Top level of the x86 integer ALU: input register, execute logic, flags
// register and result register. Depends on xalu_pkg, xalu_arith, xalu_shift
// and xalu_mul.
//
// Usage
//   Input channel (in_valid_i / in_ready_o) carries one operation per
//   transaction: mode, operand size, two operands, shift count and Jcc code.
//   Output channel (out_valid_o / out_ready_i) carries one result per
//   transaction: low and high result words, the flags after the operation
//   and the condition outcome.
//   Path: a transaction accepted into the input register has its result
//   registered in the result register as it advances, raising out_valid_o.
//   Throughput: one transaction per cycle while out_ready_i stays high.
//   The whole operation, including the 33x33 multiplier and the barrel
//   shifter, sits between the input register and the result register, and
//   the flags register is written as each operation leaves the input
//   register, so the next operation sees up-to-date flags with no bubble.
//   Stall: when out_ready_i is low with a result waiting, the input register
//   holds its operation; in_ready_o is high while it is empty or advancing.
//   Once out_ready_i returns both stages move on in the same cycle.
//   Reset: rst_ni low clears both valid bits and the flags register to zero.
`default_nettype none

module x86_integer_alu_with_flags import xalu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [4:0]  mode_i,
  input  logic [1:0]  width_sel_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  input  logic [4:0]  shift_count_i,
  input  logic [3:0]  condition_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_low_o,
  output logic [31:0] result_high_o,
  output logic [5:0]  flags_out_o,
  output logic        condition_true_o
);

  // input stage
  logic        in_valid_q, in_valid_d;
  logic [4:0]  mode_q;
  logic [1:0]  width_q;
  logic [31:0] a_q;
  logic [31:0] b_q;
  logic [4:0]  cnt_q;
  logic [3:0]  cc_q;

  // result stage
  logic        out_valid_q, out_valid_d;
  logic [31:0] res_lo_q, res_lo_d;
  logic [31:0] res_hi_q, res_hi_d;
  logic        ct_q, ct_d;

  // architectural flags
  flags_t      flags_q, flags_d;

  logic        in_fire;
  logic        advance;
  mode_e       mode;
  logic [31:0] mask;
  logic [31:0] a_m;
  logic [31:0] b_m;

  logic [31:0] arith_res;
  flags_t      arith_flags;
  logic [31:0] shift_res;
  flags_t      shift_flags;
  logic [31:0] mul_lo;
  logic [31:0] mul_hi;
  logic        mul_ovf;
  logic        cond_raw;

  // ---- handshake -----------------------------------------------------------
  assign advance    = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | advance;
  assign in_fire    = in_valid_i & in_ready_o;

  assign in_valid_d  = in_fire | (in_valid_q & ~advance);
  assign out_valid_d = advance | (out_valid_q & ~out_ready_i);

  // ---- execute -------------------------------------------------------------
  assign mode = mode_e'(mode_q);
  assign mask = width_mask(width_q);
  assign a_m  = a_q & mask;
  assign b_m  = b_q & mask;

  xalu_arith u_arith (
    .mode_i  (mode),
    .width_i (width_q),
    .a_i     (a_m),
    .b_i     (b_m),
    .flags_i (flags_q),
    .res_o   (arith_res),
    .flags_o (arith_flags)
  );

  xalu_shift u_shift (
    .mode_i  (mode),
    .width_i (width_q),
    .a_i     (a_m),
    .cnt_i   (cnt_q),
    .flags_i (flags_q),
    .res_o   (shift_res),
    .flags_o (shift_flags)
  );

  xalu_mul u_mul (
    .signed_i (mode == MODE_IMUL),
    .width_i  (width_q),
    .a_i      (a_m),
    .b_i      (b_m),
    .lo_o     (mul_lo),
    .hi_o     (mul_hi),
    .ovf_o    (mul_ovf)
  );

  // Jcc evaluation against the current flags; low bit inverts the test
  always_comb begin
    case (cc_e'(cc_q[3:1]))
      CC_O:    cond_raw = flags_q.of;
      CC_B:    cond_raw = flags_q.cf;
      CC_Z:    cond_raw = flags_q.zf;
      CC_BE:   cond_raw = flags_q.cf | flags_q.zf;
      CC_S:    cond_raw = flags_q.sf;
      CC_P:    cond_raw = flags_q.pf;
      CC_L:    cond_raw = flags_q.sf ^ flags_q.of;
      default: cond_raw = flags_q.zf | (flags_q.sf ^ flags_q.of);
    endcase
  end

  always_comb begin
    res_lo_d = 32'd0;
    res_hi_d = 32'd0;
    ct_d     = 1'b0;
    flags_d  = flags_q;
    case (mode)
      MODE_ADD, MODE_ADC, MODE_SUB, MODE_SBB, MODE_AND, MODE_OR, MODE_XOR: begin
        res_lo_d = arith_res;
        flags_d  = arith_flags;
      end
      MODE_ROL, MODE_ROR, MODE_RCL, MODE_RCR, MODE_SHL, MODE_SHR, MODE_SAR: begin
        res_lo_d = shift_res;
        flags_d  = shift_flags;
      end
      MODE_MUL, MODE_IMUL: begin
        res_lo_d   = mul_lo;
        res_hi_d   = mul_hi;
        flags_d.cf = mul_ovf;
        flags_d.of = mul_ovf;
      end
      MODE_COND: begin
        ct_d = cond_raw ^ cc_q[0];
      end
      MODE_LDF: begin
        flags_d = flags_t'(a_q[5:0]);
      end
      default: begin
        // unused modes: zero results, flags kept
        flags_d = flags_q;
      end
    endcase
  end

  // ---- registers -----------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        flags_q <= flags_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q  <= mode_i;
      width_q <= width_sel_i;
      a_q     <= operand_a_i;
      b_q     <= operand_b_i;
      cnt_q   <= shift_count_i;
      cc_q    <= condition_code_i;
    end
  end

  // flags_q after the edge equals the flags reported with this result
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_lo_q <= res_lo_d;
      res_hi_q <= res_hi_d;
      ct_q     <= ct_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_low_o     = res_lo_q;
  assign result_high_o    = res_hi_q;
  assign flags_out_o      = flags_q;
  assign condition_true_o = ct_q;

endmodule

`default_nettype wire

@@ sim/x86_integer_alu_with_flags_tb.sv @@
// Self-checking testbench for the x86 integer ALU with status flags.
// Depends on xalu_pkg and x86_integer_alu_with_flags; drives both valid/ready
// channels and checks every result transaction against an in-bench flag model.

module x86_integer_alu_with_flags_tb;
  import xalu_pkg::*;

  // Spare width code (behaves as 32 bits) and the span of modes that do nothing
  localparam logic [1:0] WIDTH_SPARE       = 2'd3;
  localparam logic [4:0] MODE_FIRST_UNUSED = 5'd18;
  localparam logic [4:0] MODE_LAST_UNUSED  = 5'd31;

  localparam int RANDOM_ITEMS = 1400;
  localparam int HOLD_CYCLES  = 60;    // long receiver hold-off
  localparam int STALL_LIMIT  = 2000;  // cycles with no transaction on either side
  localparam int MAX_REPORTS  = 10;

  // One operation as presented on the input channel
  typedef struct packed {
    logic [4:0]  mode;
    logic [1:0]  ws;
    logic [31:0] a;
    logic [31:0] b;
    logic [4:0]  cnt;
    logic [3:0]  cc;
  } alu_op_t;

  // One result as carried on the output channel
  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] hi;
    flags_t      fl;
    logic        ct;
  } alu_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [4:0]  mode_i;
  logic [1:0]  width_sel_i;
  logic [31:0] operand_a_i;
  logic [31:0] operand_b_i;
  logic [4:0]  shift_count_i;
  logic [3:0]  condition_code_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] result_low_o;
  logic [31:0] result_high_o;
  logic [5:0]  flags_out_o;
  logic        condition_true_o;

  // Expected results in transaction order, and the model's copy of the flags
  alu_res_t result_q[$];
  flags_t   flag_state;
  int       mismatch_count;

  // quiet: no idling on either side; hold_req: ask the receiver for a long hold-off
  bit quiet;
  bit hold_req;

  x86_integer_alu_with_flags dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .width_sel_i      (width_sel_i),
    .operand_a_i      (operand_a_i),
    .operand_b_i      (operand_b_i),
    .shift_count_i    (shift_count_i),
    .condition_code_i (condition_code_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_low_o     (result_low_o),
    .result_high_o    (result_high_o),
    .flags_out_o      (flags_out_o),
    .condition_true_o (condition_true_o)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Flag model
  // ---------------------------------------------------------------------------

  // PF from the low byte, ZF from the whole masked result, SF from its top bit
  function automatic flags_t with_szp(flags_t f, logic [31:0] s, logic [31:0] sgn);
    flags_t r;
    r    = f;
    r.pf = ~(^s[7:0]);
    r.zf = (s == 32'd0);
    r.sf = |(s & sgn);
    return r;
  endfunction

  // Works out the result of one operation given the flags before it; the
  // returned flags become the new flag state.
  function automatic alu_res_t alu_predict(alu_op_t op, flags_t fin);
    alu_res_t    res;
    flags_t      f;
    int unsigned nbits;
    logic [31:0] mask, sgn, a, b, s, t;
    logic [63:0] wide, x, y, p;
    logic        c, cin, top, low, ovf, hit;
    int          i;
    f   = fin;
    res = '0;
    case (op.ws)
      WIDTH_8:  nbits = 8;
      WIDTH_16: nbits = 16;
      default:  nbits = 32;   // spare code is 32 bits as well
    endcase
    mask = (nbits == 32) ? 32'hFFFF_FFFF : ((32'd1 << nbits) - 32'd1);
    sgn  = 32'd1 << (nbits - 1);
    a    = op.a & mask;
    b    = op.b & mask;
    c    = f.cf;
    case (op.mode)
      MODE_ADD, MODE_ADC: begin
        cin    = (op.mode == MODE_ADC) & c;
        wide   = {32'd0, a} + {32'd0, b} + {63'd0, cin};
        s      = wide[31:0] & mask;
        t      = a ^ b ^ s;
        f.cf   = wide[nbits];
        f.af   = t[4];
        f.of   = |((a ^ s) & (b ^ s) & sgn);
        f      = with_szp(f, s, sgn);
        res.lo = s;
      end
      MODE_SUB, MODE_SBB: begin
        cin    = (op.mode == MODE_SBB) & c;
        s      = (a - b - {31'd0, cin}) & mask;
        t      = a ^ b ^ s;
        f.cf   = ({32'd0, b} + {63'd0, cin}) > {32'd0, a};
        f.af   = t[4];
        f.of   = |((a ^ b) & (a ^ s) & sgn);
        f      = with_szp(f, s, sgn);
        res.lo = s;
      end
      MODE_AND, MODE_OR, MODE_XOR: begin
        s = (op.mode == MODE_AND) ? (a & b) : (op.mode == MODE_OR) ? (a | b) : (a ^ b);
        f.cf   = 1'b0;
        f.of   = 1'b0;
        f      = with_szp(f, s, sgn);
        res.lo = s;
      end
      MODE_ROL: begin
        for (i = 0; i < op.cnt; i++) begin
          top = |(a & sgn);
          a   = ((a << 1) | {31'd0, top}) & mask;
        end
        if (op.cnt != 0) begin
          f.cf = a[0];
          f.of = (op.cnt == 1) && ((|(a & sgn)) ^ a[0]);
        end
        res.lo = a;
      end
      MODE_ROR: begin
        for (i = 0; i < op.cnt; i++) begin
          low = a[0];
          a   = (a >> 1) | (low ? sgn : 32'd0);
        end
        if (op.cnt != 0) begin
          f.cf = |(a & sgn);
          f.of = (op.cnt == 1) && (a[nbits - 1] ^ a[nbits - 2]);
        end
        res.lo = a;
      end
      MODE_RCL: begin
        for (i = 0; i < op.cnt; i++) begin
          top = |(a & sgn);
          a   = ((a << 1) | {31'd0, c}) & mask;
          c   = top;
        end
        if (op.cnt != 0) begin
          f.cf = c;
          if (op.cnt == 1) f.of = (|(a & sgn)) ^ c;
        end
        res.lo = a;
      end
      MODE_RCR: begin
        // OF comes from the operand before the rotate
        if (op.cnt == 1) f.of = (|(a & sgn)) ^ c;
        for (i = 0; i < op.cnt; i++) begin
          low = a[0];
          a   = (a >> 1) | (c ? sgn : 32'd0);
          c   = low;
        end
        if (op.cnt != 0) f.cf = c;
        res.lo = a;
      end
      MODE_SHL, MODE_SHR, MODE_SAR: begin
        top = |(a & sgn);
        for (i = 0; i < op.cnt; i++) begin
          if (op.mode == MODE_SHL) begin
            c = |(a & sgn);
            a = (a << 1) & mask;
          end else begin
            c = a[0];
            a = (a >> 1) | ((op.mode == MODE_SAR) ? (a & sgn) : 32'd0);
          end
        end
        if (op.cnt != 0) begin
          f.cf = c;
          f    = with_szp(f, a, sgn);
          f.of = 1'b0;
          if (op.cnt == 1) begin
            if (op.mode == MODE_SHL)      f.of = (|(a & sgn)) ^ c;
            else if (op.mode == MODE_SHR) f.of = top;
          end
        end
        res.lo = a;
      end
      MODE_MUL, MODE_IMUL: begin
        x = {32'd0, a};
        y = {32'd0, b};
        if (op.mode == MODE_IMUL) begin
          x = (x ^ {32'd0, sgn}) - {32'd0, sgn};
          y = (y ^ {32'd0, sgn}) - {32'd0, sgn};
        end
        p      = x * y;
        wide   = p >> nbits;
        res.lo = p[31:0] & mask;
        res.hi = wide[31:0] & mask;
        if (op.mode == MODE_MUL) ovf = (res.hi != 32'd0);
        else                     ovf = (res.hi != ((|(res.lo & sgn)) ? mask : 32'd0));
        f.cf = ovf;
        f.of = ovf;
      end
      MODE_COND: begin
        case (cc_e'(op.cc[3:1]))
          CC_O:    hit = f.of;
          CC_B:    hit = f.cf;
          CC_Z:    hit = f.zf;
          CC_BE:   hit = f.cf | f.zf;
          CC_S:    hit = f.sf;
          CC_P:    hit = f.pf;
          CC_L:    hit = f.sf ^ f.of;
          default: hit = f.zf | (f.sf ^ f.of);
        endcase
        res.ct = hit ^ op.cc[0];   // odd codes are the negated forms
      end
      MODE_LDF: f = flags_t'(op.a[5:0]);
      default: ;                    // unused modes leave everything alone
    endcase
    res.fl = f;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  // Edge or random values at the given size, sometimes with junk above the size
  function automatic logic [31:0] rand_operand(logic [1:0] ws);
    logic [31:0] mask, sgn, v;
    case (ws)
      WIDTH_8:  mask = 32'h0000_00FF;
      WIDTH_16: mask = 32'h0000_FFFF;
      default:  mask = 32'hFFFF_FFFF;
    endcase
    sgn = (mask >> 1) + 32'd1;
    case ($urandom_range(7, 0))
      0:       v = 32'd0;
      1:       v = mask;
      2:       v = sgn;
      3:       v = sgn - 32'd1;
      4:       v = 32'd1;
      default: v = $urandom();
    endcase
    if ($urandom_range(1, 0) == 1) v = v | ($urandom() & ~mask);
    return v;
  endfunction

  // Offers one operation, holds it until accepted, then books its result
  task automatic send_op(input logic [4:0] mode, input logic [1:0] ws,
                         input logic [31:0] a, input logic [31:0] b,
                         input logic [4:0] cnt, input logic [3:0] cc);
    int       gap;
    alu_op_t  op;
    alu_res_t res;
    gap = pick_gap();
    op  = '{mode: mode, ws: ws, a: a, b: b, cnt: cnt, cc: cc};
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    mode_i           <= mode;
    width_sel_i      <= ws;
    operand_a_i      <= a;
    operand_b_i      <= b;
    shift_count_i    <= cnt;
    condition_code_i <= cc;
    in_valid_i       <= 1'b1;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    // Accepted at this edge: flags move on in transaction order
    res        = alu_predict(op, flag_state);
    flag_state = res.fl;
    result_q.push_back(res);
  endtask

  task automatic send_random_op();
    logic [4:0]  mode;
    logic [1:0]  ws;
    logic [4:0]  cnt;
    int          r;
    int unsigned nb;
    r = $urandom_range(99, 0);
    if (r < 4)       mode = MODE_LDF;
    else if (r < 12) mode = MODE_COND;
    else if (r < 14) mode = 5'($urandom_range(MODE_LAST_UNUSED, MODE_FIRST_UNUSED));
    else             mode = 5'($urandom_range(MODE_IMUL, MODE_ADD));
    ws = ($urandom_range(9, 0) == 0) ? WIDTH_SPARE : 2'($urandom_range(WIDTH_32, WIDTH_8));
    nb = (ws == WIDTH_8) ? 8 : (ws == WIDTH_16) ? 16 : 32;
    // counts cluster around 0, 1 and the width boundary
    case ($urandom_range(5, 0))
      0, 1:    cnt = 5'($urandom());
      2:       cnt = 5'd0;
      3:       cnt = 5'd1;
      4:       cnt = 5'(nb - 1 + $urandom_range(2, 0));
      default: cnt = 5'($urandom_range(3, 2));
    endcase
    send_op(mode, ws, rand_operand(ws), rand_operand(ws), cnt, 4'($urandom()));
  endtask

  // Sender goes idle until every booked result has come back
  task automatic wait_results_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Carries, borrows, overflow, masking of upper operand bits, spare width code
  task automatic test_operation_edges();
    send_op(MODE_ADD,  WIDTH_8,     32'h0000_00FF, 32'h0000_0001, 5'd0, 4'd0);
    send_op(MODE_ADC,  WIDTH_16,    32'hABCD_7FFF, 32'hFFFF_0000, 5'd0, 4'd0);
    send_op(MODE_SUB,  WIDTH_32,    32'h0000_0000, 32'h0000_0001, 5'd0, 4'd0);
    send_op(MODE_SBB,  WIDTH_SPARE, 32'h8000_0000, 32'h7FFF_FFFF, 5'd0, 4'd0);
    send_op(MODE_AND,  WIDTH_32,    32'hFFFF_FFFF, 32'h8000_0000, 5'd0, 4'd0);
    send_op(MODE_OR,   WIDTH_8,     32'hFFFF_FF00, 32'h0000_0000, 5'd0, 4'd0);
    send_op(MODE_XOR,  WIDTH_16,    32'h0000_5555, 32'h0000_FFFF, 5'd0, 4'd0);
    send_op(MODE_MUL,  WIDTH_32,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0, 4'd0);
    send_op(MODE_IMUL, WIDTH_8,     32'h0000_0080, 32'h0000_0080, 5'd0, 4'd0);
    send_op(MODE_IMUL, WIDTH_16,    32'h0000_FFFF, 32'h0000_FFFF, 5'd0, 4'd0);
    send_op(MODE_MUL,  WIDTH_8,     32'h0000_000F, 32'h0000_0011, 5'd0, 4'd0);
  endtask

  // Zero count, count of one, counts past the width, shifting out everything
  task automatic test_rotate_shift_edges();
    send_op(MODE_ROL, WIDTH_8,  32'h0000_0081, 32'd0, 5'd0,  4'd0);
    send_op(MODE_ROL, WIDTH_8,  32'h0000_0081, 32'd0, 5'd1,  4'd0);
    send_op(MODE_ROR, WIDTH_16, 32'h0000_0001, 32'd0, 5'd1,  4'd0);
    send_op(MODE_RCL, WIDTH_8,  32'h0000_0080, 32'd0, 5'd9,  4'd0);
    send_op(MODE_RCR, WIDTH_32, 32'h0000_0001, 32'd0, 5'd31, 4'd0);
    send_op(MODE_SHL, WIDTH_8,  32'h0000_00FF, 32'd0, 5'd8,  4'd0);
    send_op(MODE_SHR, WIDTH_16, 32'h0000_8000, 32'd0, 5'd1,  4'd0);
    send_op(MODE_SAR, WIDTH_16, 32'h0000_8000, 32'd0, 5'd31, 4'd0);
    send_op(MODE_SHL, WIDTH_32, 32'hC000_0000, 32'd0, 5'd1,  4'd0);
  endtask

  // Flag load, Jcc evaluation against loaded flags, and the do-nothing modes
  task automatic test_flag_modes();
    send_op(MODE_LDF,          WIDTH_8,     32'h0000_003F, 32'd0, 5'd0, 4'd0);
    send_op(MODE_COND,         WIDTH_8,     32'd0,         32'd0, 5'd0, 4'd0);
    send_op(MODE_COND,         WIDTH_16,    32'd0,         32'd0, 5'd0, 4'd15);
    send_op(MODE_LDF,          WIDTH_32,    32'hFFFF_FFC0, 32'd0, 5'd0, 4'd0);
    send_op(MODE_COND,         WIDTH_32,    32'd0,         32'd0, 5'd0, 4'd14);
    send_op(MODE_FIRST_UNUSED, WIDTH_8,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 4'd15);
    send_op(MODE_LAST_UNUSED,  WIDTH_SPARE, 32'h1234_5678, 32'h9ABC_DEF0, 5'd1,  4'd7);
  endtask

  // Receiver holds off while the sender keeps offering, so the block fills
  // and drops in_ready_o; afterwards the sender waits for a full drain.
  task automatic test_back_pressure();
    int n;
    quiet    = 1'b1;
    hold_req = 1'b1;
    for (n = 0; n < 20; n++) send_random_op();
    quiet = 1'b0;
    wait_results_drained();
  endtask

  task automatic test_random_traffic();
    int n;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n < 200) || (n >= 900 && n < 1000);
      if (n == 600) wait_results_drained();
      send_random_op();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus the long hold-off when requested
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    int stall_left;
    hold_left   = 0;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (!quiet && $urandom_range(99, 0) < 15) stall_left = 1 + pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: each output transaction against the oldest booked result
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    alu_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (result_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: lo=%h hi=%h flags=%b ct=%b",
                   result_low_o, result_high_o, flags_out_o, condition_true_o);
      end else begin
        want = result_q.pop_front();
        if (result_low_o !== want.lo || result_high_o !== want.hi ||
            flags_out_o !== want.fl || condition_true_o !== want.ct) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("result mismatch: exp lo=%h hi=%h flags=%b ct=%b,",
                     want.lo, want.hi, want.fl, want.ct,
                     " got lo=%h hi=%h flags=%b ct=%b",
                     result_low_o, result_high_o, flags_out_o, condition_true_o);
        end
      end
    end
  end

  // Watchdog: too long with no transaction on either channel ends the run
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence of tests
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    mode_i           = '0;
    width_sel_i      = '0;
    operand_a_i      = '0;
    operand_b_i      = '0;
    shift_count_i    = '0;
    condition_code_i = '0;
    flag_state       = '0;
    mismatch_count   = 0;
    quiet            = 1'b0;
    hold_req         = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_operation_edges();
    test_rotate_shift_edges();
    test_flag_modes();
    test_back_pressure();
    test_random_traffic();

    // drain, then a few cycles so a stray result would still be caught
    wait_results_drained();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0 && result_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
